>>> design/stereo_gain_ramp_peak_meter_unit_assert.svh
// assertion macros for the stereo gain ramp and peak meter unit
// used by the port checker; expects signals named clock and reset in scope
`ifndef STEREO_GAIN_RAMP_PEAK_METER_UNIT_ASSERT_SVH
`define STEREO_GAIN_RAMP_PEAK_METER_UNIT_ASSERT_SVH

// same-cycle implication
`define SGR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SGR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/sgr_pkg.sv
// shared constants, control structs and the level threshold function
// for the stereo gain ramp and peak meter unit; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sgr_pkg;

   localparam int GAIN_W    = 12;
   localparam int SAMPLE_W  = 16;
   localparam int MAG_W     = 15;
   localparam int PROD_W    = 28;
   localparam int LEVEL_W   = 7;
   localparam int LEVEL_MAX = 100;

   localparam logic [GAIN_W-1:0] RAMP_STEP  = 12'd10;
   localparam logic [GAIN_W-1:0] GAIN_UNITY = 12'd1000;
   localparam logic [MAG_W-1:0]  SAMPLE_LIMIT = 15'd32767;

   // |sample * gain| at or above this gives a quotient beyond the limit
   localparam logic [PROD_W-1:0] CLAMP_PRODUCT = 28'd32768000;

   // floor(m / 1000) == (m * DIV_RECIP) >> DIV_SHIFT for m < 2**25
   localparam int              DIV_IN_W  = 25;
   localparam int              RECIP_W   = 26;
   localparam logic [RECIP_W-1:0] DIV_RECIP = 26'd34359739;
   localparam int              DIV_SHIFT = 35;
   localparam int              DIV_PROD_W = DIV_IN_W + RECIP_W;

   localparam int SMOOTH_W     = 10;
   localparam logic [SMOOTH_W-1:0] SMOOTH_OLD = 10'd7;
   localparam int SMOOTH_SHIFT = 3;

   typedef struct packed {
      logic load2;
      logic load3;
   } lane_ctl_type;

   typedef struct packed {
      logic load4;
      logic load5;
      logic last3;
      logic last4;
   } meter_ctl_type;

   // smallest peak that reaches level n: ceil(32767 * 10^((n - 100) / 50))
   function automatic logic [MAG_W-1:0] level_threshold(input int n);
      real expo;
      real thr;
      expo = (real'(n) - real'(LEVEL_MAX)) / 50.0;
      thr  = $ceil(real'(SAMPLE_LIMIT) * $pow(10.0, expo));
      return MAG_W'(int'(thr));
   endfunction

endpackage

`default_nettype wire

>>> design/stereo_gain_ramp_peak_meter_unit.sv
// top level of the stereo gain ramp and peak meter unit
// uses sgr_pkg, sgr_chan_scale and sgr_level_meter
//
//   port group   direction   handshake             payload
//   req_*        in          req_valid/req_stall   left_in, right_in, last_frame
//   rsp_*        out         rsp_valid/rsp_stall   left_out, right_out,
//                                                  meter_level, end_of_buffer
//   csr_*        in          csr_wr_en             wr_data (target gain)
//
// one request per cycle sustained while rsp_stall is low; accept to rsp_valid
// passes input reg, product reg, quotient reg, peak/threshold reg, result reg
// each stage holds only while full and its successor is blocked, so bubbles
// close up and a request is taken whenever the result stage is empty or taken
// synchronous reset clears valids, peak and level, sets gain to unity; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module stereo_gain_ramp_peak_meter_unit (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   csr_wr_en,
   input  wire        [sgr_pkg::GAIN_W-1:0]      csr_wr_data,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire signed [sgr_pkg::SAMPLE_W-1:0]    req_left_in,
   input  wire signed [sgr_pkg::SAMPLE_W-1:0]    req_right_in,
   input  wire                                   req_last_frame,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic signed [sgr_pkg::SAMPLE_W-1:0]   rsp_left_out,
   output logic signed [sgr_pkg::SAMPLE_W-1:0]   rsp_right_out,
   output logic       [sgr_pkg::LEVEL_W-1:0]     rsp_meter_level,
   output logic                                  rsp_end_of_buffer
);

   logic [sgr_pkg::GAIN_W-1:0] target_ff;
   logic [sgr_pkg::GAIN_W-1:0] gain_ff;
   logic [sgr_pkg::GAIN_W-1:0] gain_in;
   logic [sgr_pkg::GAIN_W:0]   gain_up;
   logic [sgr_pkg::GAIN_W:0]   target_up;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;
   logic load1;
   sgr_pkg::lane_ctl_type  lane_ctl;
   sgr_pkg::meter_ctl_type meter_ctl;

   logic signed [sgr_pkg::SAMPLE_W-1:0] s1_left_ff, s1_right_ff;
   logic [sgr_pkg::GAIN_W-1:0]          s1_gain_ff;
   logic s1_last_ff, s2_last_ff, s3_last_ff, s4_last_ff, s5_last_ff;

   logic signed [sgr_pkg::SAMPLE_W-1:0] s3_left, s3_right;
   logic [sgr_pkg::MAG_W-1:0]           s3_mag_left, s3_mag_right;
   logic signed [sgr_pkg::SAMPLE_W-1:0] s4_left_ff, s4_right_ff;
   logic signed [sgr_pkg::SAMPLE_W-1:0] s5_left_ff, s5_right_ff;

   // pipeline flow control
   always_comb begin
      rdy5      = !v5_ff || !rsp_stall;
      rdy4      = !v4_ff || rdy5;
      rdy3      = !v3_ff || rdy4;
      rdy2      = !v2_ff || rdy3;
      rdy1      = !v1_ff || rdy2;
      load1     = req_valid && rdy1;
      req_stall = !rdy1;
      lane_ctl.load2  = v1_ff && rdy2;
      lane_ctl.load3  = v2_ff && rdy3;
      meter_ctl.load4 = v3_ff && rdy4;
      meter_ctl.load5 = v4_ff && rdy5;
      meter_ctl.last3 = s3_last_ff;
      meter_ctl.last4 = s4_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
      end
   end

   // gain ramp toward target, one step per request
   always_comb begin
      gain_up   = {1'b0, gain_ff} + {1'b0, sgr_pkg::RAMP_STEP};
      target_up = {1'b0, target_ff} + {1'b0, sgr_pkg::RAMP_STEP};
      if (gain_up < {1'b0, target_ff}) begin
         gain_in = gain_ff + sgr_pkg::RAMP_STEP;
      end else if ({1'b0, gain_ff} > target_up) begin
         gain_in = gain_ff - sgr_pkg::RAMP_STEP;
      end else begin
         gain_in = target_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= sgr_pkg::GAIN_UNITY;
         gain_ff   <= sgr_pkg::GAIN_UNITY;
      end else begin
         if (csr_wr_en) target_ff <= csr_wr_data;
         if (load1)     gain_ff   <= gain_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (load1) begin
         s1_left_ff  <= req_left_in;
         s1_right_ff <= req_right_in;
         s1_gain_ff  <= gain_in;
         s1_last_ff  <= req_last_frame;
      end
      if (lane_ctl.load2)  s2_last_ff <= s1_last_ff;
      if (lane_ctl.load3)  s3_last_ff <= s2_last_ff;
      if (meter_ctl.load4) begin
         s4_left_ff  <= s3_left;
         s4_right_ff <= s3_right;
         s4_last_ff  <= s3_last_ff;
      end
      if (meter_ctl.load5) begin
         s5_left_ff  <= s4_left_ff;
         s5_right_ff <= s4_right_ff;
         s5_last_ff  <= s4_last_ff;
      end
   end

   sgr_chan_scale u_scale_left (
      .clock     (clock),
      .ctl       (lane_ctl),
      .sample    (s1_left_ff),
      .gain      (s1_gain_ff),
      .value     (s3_left),
      .magnitude (s3_mag_left)
   );

   sgr_chan_scale u_scale_right (
      .clock     (clock),
      .ctl       (lane_ctl),
      .sample    (s1_right_ff),
      .gain      (s1_gain_ff),
      .value     (s3_right),
      .magnitude (s3_mag_right)
   );

   sgr_level_meter u_meter (
      .clock     (clock),
      .reset     (reset),
      .ctl       (meter_ctl),
      .mag_left  (s3_mag_left),
      .mag_right (s3_mag_right),
      .level     (rsp_meter_level)
   );

   assign rsp_valid         = v5_ff;
   assign rsp_left_out      = s5_left_ff;
   assign rsp_right_out     = s5_right_ff;
   assign rsp_end_of_buffer = s5_last_ff;

endmodule

`default_nettype wire

>>> design/sgr_chan_scale.sv
// one channel lane: sample times gain, then divide by 1000 with clamp
// two registered stages; uses sgr_pkg
`timescale 1ns / 1ps
`default_nettype none

module sgr_chan_scale (
   input  wire                                   clock,
   input  wire sgr_pkg::lane_ctl_type            ctl,
   input  wire signed [sgr_pkg::SAMPLE_W-1:0]    sample,
   input  wire        [sgr_pkg::GAIN_W-1:0]      gain,
   output logic signed [sgr_pkg::SAMPLE_W-1:0]   value,
   output logic       [sgr_pkg::MAG_W-1:0]       magnitude
);

   logic [sgr_pkg::SAMPLE_W-1:0]   abs_sample;
   logic [sgr_pkg::PROD_W-1:0]     mag_in;
   logic [sgr_pkg::PROD_W-1:0]     mag_ff;
   logic                           neg_ff;
   logic                           over;
   logic [sgr_pkg::DIV_PROD_W-1:0] quot_prod;
   logic [sgr_pkg::MAG_W-1:0]      quot_in;
   logic signed [sgr_pkg::SAMPLE_W-1:0] value_in;
   logic signed [sgr_pkg::SAMPLE_W-1:0] value_ff;
   logic [sgr_pkg::MAG_W-1:0]      mag_out_ff;

   // magnitude product
   always_comb begin
      abs_sample = sample[sgr_pkg::SAMPLE_W-1] ? (~sample + 16'd1) : sample;
      mag_in     = sgr_pkg::PROD_W'(abs_sample) * sgr_pkg::PROD_W'(gain);
   end

   always_ff @(posedge clock) begin
      if (ctl.load2) begin
         mag_ff <= mag_in;
         neg_ff <= sample[sgr_pkg::SAMPLE_W-1];
      end
   end

   // divide by 1000 via reciprocal, clamp, restore sign
   always_comb begin
      over      = mag_ff >= sgr_pkg::CLAMP_PRODUCT;
      quot_prod = sgr_pkg::DIV_PROD_W'(mag_ff[sgr_pkg::DIV_IN_W-1:0])
                  * sgr_pkg::DIV_PROD_W'(sgr_pkg::DIV_RECIP);
      quot_in   = over ? sgr_pkg::SAMPLE_LIMIT
                       : quot_prod[sgr_pkg::DIV_SHIFT +: sgr_pkg::MAG_W];
      value_in  = neg_ff ? -$signed(sgr_pkg::SAMPLE_W'(quot_in))
                         : $signed(sgr_pkg::SAMPLE_W'(quot_in));
   end

   always_ff @(posedge clock) begin
      if (ctl.load3) begin
         value_ff   <= value_in;
         mag_out_ff <= quot_in;
      end
   end

   assign value     = value_ff;
   assign magnitude = mag_out_ff;

endmodule

`default_nettype wire

>>> design/sgr_level_meter.sv
// buffer peak tracking, threshold compare and smoothed level register
// two registered stages; uses sgr_pkg
`timescale 1ns / 1ps
`default_nettype none

module sgr_level_meter (
   input  wire                              clock,
   input  wire                              reset,
   input  wire sgr_pkg::meter_ctl_type      ctl,
   input  wire [sgr_pkg::MAG_W-1:0]         mag_left,
   input  wire [sgr_pkg::MAG_W-1:0]         mag_right,
   output logic [sgr_pkg::LEVEL_W-1:0]      level
);

   logic [sgr_pkg::MAG_W-1:0]     frame_peak;
   logic [sgr_pkg::MAG_W-1:0]     peak_in;
   logic [sgr_pkg::MAG_W-1:0]     peak_ff;
   logic [sgr_pkg::LEVEL_MAX-1:0] thr_hit;
   logic [sgr_pkg::LEVEL_MAX-1:0] therm_ff;
   logic [sgr_pkg::LEVEL_W-1:0]   raw_level;
   logic [sgr_pkg::SMOOTH_W-1:0]  smooth_sum;
   logic [sgr_pkg::LEVEL_W-1:0]   level_in;
   logic [sgr_pkg::LEVEL_W-1:0]   level_ff;

   always_comb begin
      frame_peak = (mag_left > mag_right) ? mag_left : mag_right;
      peak_in    = (frame_peak > peak_ff) ? frame_peak : peak_ff;
   end

   for (genvar gi = 0; gi < sgr_pkg::LEVEL_MAX; gi++) begin : g_thr
      localparam logic [sgr_pkg::MAG_W-1:0] THR = sgr_pkg::level_threshold(gi + 1);
      assign thr_hit[gi] = peak_in >= THR;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff <= '0;
      end else if (ctl.load4) begin
         peak_ff <= ctl.last3 ? '0 : peak_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load4) begin
         therm_ff <= thr_hit;
      end
   end

   // at buffer end a rising level is taken at once, a falling level smoothed
   always_comb begin
      raw_level  = sgr_pkg::LEVEL_W'($countones(therm_ff));
      smooth_sum = sgr_pkg::SMOOTH_W'(level_ff) * sgr_pkg::SMOOTH_OLD
                   + sgr_pkg::SMOOTH_W'(raw_level);
      if (!ctl.last4) begin
         level_in = level_ff;
      end else if (raw_level > level_ff) begin
         level_in = raw_level;
      end else begin
         level_in = sgr_pkg::LEVEL_W'(smooth_sum >> sgr_pkg::SMOOTH_SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else if (ctl.load5) begin
         level_ff <= level_in;
      end
   end

   assign level = level_ff;

endmodule

`default_nettype wire

>>> design/sgr_port_checker.sv
// port-level checks for the stereo gain ramp and peak meter unit
// uses sgr_pkg and the assertion macro header; bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "stereo_gain_ramp_peak_meter_unit_assert.svh"

module sgr_port_checker (
   input wire                                  clock,
   input wire                                  reset,
   input wire                                  req_stall,
   input wire                                  rsp_valid,
   input wire                                  rsp_stall,
   input wire signed [sgr_pkg::SAMPLE_W-1:0]   rsp_left_out,
   input wire signed [sgr_pkg::SAMPLE_W-1:0]   rsp_right_out,
   input wire        [sgr_pkg::LEVEL_W-1:0]    rsp_meter_level,
   input wire                                  rsp_end_of_buffer
);

   logic                                              rsp_wait;
   logic                                              neg_full;
   logic [2*sgr_pkg::SAMPLE_W+sgr_pkg::LEVEL_W:0]     rsp_payload;

   assign rsp_wait    = rsp_valid && rsp_stall;
   assign neg_full    = (rsp_left_out == 16'sh8000) || (rsp_right_out == 16'sh8000);
   assign rsp_payload = {rsp_left_out, rsp_right_out, rsp_meter_level, rsp_end_of_buffer};

   `SGR_ASSERT_NEXT(a_rsp_hold, rsp_wait, rsp_valid, "stalled response dropped")

   `SGR_ASSERT_NEXT(a_rsp_stable, rsp_wait, $stable(rsp_payload), "stalled response changed")

   `SGR_ASSERT_NOW(a_req_open, !rsp_wait, !req_stall, "request stalled with free output")

   `SGR_ASSERT_NOW(a_level_range, rsp_valid, rsp_meter_level <= 7'd100, "level above full scale")

   `SGR_ASSERT_NOW(a_sample_clamp, rsp_valid, !neg_full, "sample outside clamp range")

endmodule

bind stereo_gain_ramp_peak_meter_unit sgr_port_checker u_port_checker (.*);

`default_nettype wire
